// ===== rtl/pst_pkg.sv =====
`default_nettype none
package pst_pkg;

  localparam int unsigned FRAC_BITS = 8;
  localparam int unsigned VERTS     = 10;
  localparam int unsigned COORD_W   = 16;
  localparam int unsigned VTX_W     = 25;
  localparam int unsigned SUM_W     = 26;
  localparam logic signed [SUM_W-1:0] VTX_LIMIT = 26'sd8389120;

  // configuration register indexes
  localparam logic [1:0] CFG_COLOR   = 2'd0;
  localparam logic [1:0] CFG_INNER   = 2'd1;
  localparam logic [1:0] CFG_FEATHER = 2'd2;
  localparam logic [1:0] CFG_UNUSED  = 2'd3;

  // datapath operations
  typedef enum logic [3:0] {
    OP_NOP, OP_LOAD, OP_DIFF, OP_SQX, OP_SQY, OP_LEN, OP_UINIT, OP_USTEP,
    OP_USTORE, OP_OFF, OP_VTX, OP_SHIFT
  } dp_op_e;

  typedef struct packed {
    dp_op_e     op;
    logic       seg;   // 0: waiting segment, 1: closing segment
    logic       nsel;  // 0: normal at a, 1: normal at b
    logic       comp;  // 0: x component, 1: y component
    logic [3:0] idx;
    logic [1:0] k;     // points seen before this point
    logic       last;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } sts_t;

  // strip vertex sits on end point b
  function automatic logic vtx_at_b(input logic [3:0] j);
    case (j)
      4'd2, 4'd4, 4'd6, 4'd8, 4'd9: vtx_at_b = 1'b1;
      default:                      vtx_at_b = 1'b0;
    endcase
  endfunction

  // strip vertex on the negative side
  function automatic logic vtx_neg(input logic [3:0] j);
    vtx_neg = (j >= 4'd5);
  endfunction

  // strip vertex on the outer (feathered) edge
  function automatic logic vtx_outer(input logic [3:0] j);
    vtx_outer = (j <= 4'd2) || (j >= 4'd7);
  endfunction

endpackage
`default_nettype wire

// ===== rtl/pst_dp.sv =====
`default_nettype none
module pst_dp (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire pst_pkg::cmd_t       cmd_i,
  output pst_pkg::sts_t            sts_o,
  input  wire logic signed [15:0]  point_x_i,
  input  wire logic signed [15:0]  point_y_i,
  input  wire logic                cfg_valid_i,
  input  wire logic [1:0]          cfg_index_i,
  input  wire logic [31:0]         cfg_data_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output logic signed [24:0]       vertex_x_o,
  output logic signed [24:0]       vertex_y_o,
  output logic [7:0]               red_o,
  output logic [7:0]               green_o,
  output logic [7:0]               blue_o,
  output logic [7:0]               alpha_o,
  output logic [3:0]               vertex_index_o,
  output logic                     last_of_item_o
);

  logic [31:0] color_q;
  logic [11:0] inner_q, feather_q;
  logic signed [15:0] cur_x_q, cur_y_q, prev_x_q, prev_y_q;
  logic signed [15:0] older_x_q, older_y_q, oldest_x_q, oldest_y_q;
  logic signed [16:0] dx_q, dy_q;
  logic [31:0] sqx_q, sqy_q;
  logic [32:0] len2_q;
  logic [63:0] r_q, acc_q, a_q, lk_q;
  logic [15:0] s_q, bit_q;
  logic signed [15:0] nx_q [2];
  logic signed [15:0] ny_q [2];
  logic [29:0] off_q [4];
  logic out_valid_q;

  logic signed [15:0] aa_x, aa_y, a_x, a_y, b_x, b_y, bb_x, bb_y;
  logic signed [16:0] d_x, d_y;
  logic [15:0] mag_x, mag_y, mul_a, mul_b;
  logic [31:0] mul_p;
  logic [65:0] trial;
  logic [16:0] m_full;
  logic [15:0] m_val;
  logic signed [15:0] n_sel;
  logic [14:0] n_mag;
  logic [12:0] width;
  logic [13:0] off_mag;
  logic signed [14:0] off_val;
  logic v_b, v_neg, v_outer;
  logic [29:0] off_pair;
  logic signed [15:0] px, py;
  logic signed [pst_pkg::SUM_W-1:0] sum_x, sum_y;

  // segment end points
  always_comb begin
    if (!cmd_i.seg) begin
      aa_x = (cmd_i.k == 2'd3) ? oldest_x_q : older_x_q;
      aa_y = (cmd_i.k == 2'd3) ? oldest_y_q : older_y_q;
      a_x = older_x_q; a_y = older_y_q;
      b_x = prev_x_q;  b_y = prev_y_q;
      bb_x = cur_x_q;  bb_y = cur_y_q;
    end else begin
      aa_x = (cmd_i.k >= 2'd2) ? older_x_q : prev_x_q;
      aa_y = (cmd_i.k >= 2'd2) ? older_y_q : prev_y_q;
      a_x = prev_x_q; a_y = prev_y_q;
      b_x = cur_x_q;  b_y = cur_y_q;
      bb_x = cur_x_q; bb_y = cur_y_q;
    end
  end

  // direction vector of the selected normal
  always_comb begin
    if (cmd_i.nsel) begin
      d_x = {bb_x[15], bb_x} - {a_x[15], a_x};
      d_y = {bb_y[15], bb_y} - {a_y[15], a_y};
    end else begin
      d_x = {b_x[15], b_x} - {aa_x[15], aa_x};
      d_y = {b_y[15], b_y} - {aa_y[15], aa_y};
    end
  end

  assign mag_x = dx_q[16] ? 16'(-dx_q) : dx_q[15:0];
  assign mag_y = dy_q[16] ? 16'(-dy_q) : dy_q[15:0];

  // offset operand selection
  always_comb begin
    n_sel = cmd_i.idx[0] ? ny_q[cmd_i.idx[2]] : nx_q[cmd_i.idx[2]];
    n_mag = n_sel[15] ? 15'(-n_sel) : n_sel[14:0];
    width = cmd_i.idx[1] ? ({1'b0, inner_q} + {1'b0, feather_q}) : {1'b0, inner_q};
  end

  // shared multiplier
  always_comb begin
    case (cmd_i.op)
      pst_pkg::OP_SQX: begin mul_a = mag_x; mul_b = mag_x; end
      pst_pkg::OP_SQY: begin mul_a = mag_y; mul_b = mag_y; end
      default:         begin mul_a = {1'b0, n_mag}; mul_b = {3'b0, width}; end
    endcase
  end
  assign mul_p = mul_a * mul_b;

  assign off_mag = 14'((mul_p[26:0] + 27'd8192) >> 14);
  assign off_val = n_sel[15] ? -$signed({1'b0, off_mag}) : $signed({1'b0, off_mag});

  // square root search step
  assign trial = {2'b0, acc_q} + {2'b0, a_q} + {2'b0, lk_q};
  assign m_full = ({1'b0, s_q} + 17'd1) >> 1;
  assign m_val = (len2_q == 33'd0) ? 16'd0 : m_full[15:0];

  // vertex position
  always_comb begin
    logic [14:0] ox, oy;
    logic signed [pst_pkg::SUM_W-1:0] ex, ey;
    v_b = pst_pkg::vtx_at_b(cmd_i.idx);
    v_neg = pst_pkg::vtx_neg(cmd_i.idx);
    v_outer = pst_pkg::vtx_outer(cmd_i.idx);
    off_pair = off_q[{v_b, v_outer}];
    px = v_b ? b_x : a_x;
    py = v_b ? b_y : a_y;
    ox = off_pair[14:0];
    oy = off_pair[29:15];
    ex = {{(pst_pkg::SUM_W-15){ox[14]}}, ox};
    ey = {{(pst_pkg::SUM_W-15){oy[14]}}, oy};
    if (v_neg) begin
      ex = -ex;
      ey = -ey;
    end
    sum_x = {{(pst_pkg::SUM_W-16-pst_pkg::FRAC_BITS){px[15]}}, px,
             {pst_pkg::FRAC_BITS{1'b0}}} + ex;
    sum_y = {{(pst_pkg::SUM_W-16-pst_pkg::FRAC_BITS){py[15]}}, py,
             {pst_pkg::FRAC_BITS{1'b0}}} + ey;
  end

  function automatic logic signed [24:0] clamp(input logic signed [pst_pkg::SUM_W-1:0] v);
    if (v > pst_pkg::VTX_LIMIT) clamp = pst_pkg::VTX_LIMIT[24:0];
    else if (v < -pst_pkg::VTX_LIMIT) clamp = 25'(-pst_pkg::VTX_LIMIT);
    else clamp = v[24:0];
  endfunction

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      color_q   <= 32'hFF00_0000;
      inner_q   <= 12'd230;
      feather_q <= 12'd256;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        pst_pkg::CFG_COLOR:   color_q   <= cfg_data_i;
        pst_pkg::CFG_INNER:   inner_q   <= cfg_data_i[11:0];
        pst_pkg::CFG_FEATHER: feather_q <= cfg_data_i[11:0];
        default: ;
      endcase
    end
  end

  // point history
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_x_q <= '0; cur_y_q <= '0; prev_x_q <= '0; prev_y_q <= '0;
      older_x_q <= '0; older_y_q <= '0; oldest_x_q <= '0; oldest_y_q <= '0;
    end else begin
      case (cmd_i.op)
        pst_pkg::OP_LOAD: begin
          cur_x_q <= point_x_i;
          cur_y_q <= point_y_i;
        end
        pst_pkg::OP_SHIFT: begin
          oldest_x_q <= older_x_q; oldest_y_q <= older_y_q;
          older_x_q <= prev_x_q;   older_y_q <= prev_y_q;
          prev_x_q <= cur_x_q;     prev_y_q <= cur_y_q;
        end
        default: ;
      endcase
    end
  end

  // normal and offset datapath
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      pst_pkg::OP_DIFF: begin
        dx_q <= d_x;
        dy_q <= d_y;
      end
      pst_pkg::OP_SQX: sqx_q <= mul_p;
      pst_pkg::OP_SQY: sqy_q <= mul_p;
      pst_pkg::OP_LEN: len2_q <= {1'b0, sqx_q} + {1'b0, sqy_q};
      pst_pkg::OP_UINIT: begin
        r_q   <= {2'b0, (cmd_i.comp ? sqy_q : sqx_q), 30'b0};
        lk_q  <= {1'b0, len2_q, 30'b0};
        acc_q <= '0;
        a_q   <= '0;
        s_q   <= '0;
        bit_q <= 16'h8000;
      end
      pst_pkg::OP_USTEP: begin
        if (trial <= {2'b0, r_q}) begin
          acc_q <= trial[63:0];
          a_q   <= (a_q + {lk_q[62:0], 1'b0}) >> 1;
          s_q   <= s_q | bit_q;
        end else begin
          a_q <= a_q >> 1;
        end
        lk_q  <= lk_q >> 2;
        bit_q <= bit_q >> 1;
      end
      pst_pkg::OP_USTORE: begin
        // rotate by +90: n = (-uy, ux)
        if (cmd_i.comp) nx_q[cmd_i.nsel] <= dy_q[16] ? $signed(m_val) : -$signed(m_val);
        else            ny_q[cmd_i.nsel] <= dx_q[16] ? -$signed(m_val) : $signed(m_val);
      end
      pst_pkg::OP_OFF: begin
        if (cmd_i.idx[0]) off_q[cmd_i.idx[2:1]][29:15] <= off_val;
        else              off_q[cmd_i.idx[2:1]][14:0]  <= off_val;
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.op == pst_pkg::OP_VTX) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == pst_pkg::OP_VTX) begin
      vertex_x_o     <= clamp(sum_x);
      vertex_y_o     <= clamp(sum_y);
      red_o          <= color_q[23:16];
      green_o        <= color_q[15:8];
      blue_o         <= color_q[7:0];
      alpha_o        <= (cmd_i.idx >= 4'd3 && cmd_i.idx <= 4'd6) ? color_q[31:24] : 8'd0;
      vertex_index_o <= cmd_i.idx;
      last_of_item_o <= cmd_i.last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign sts_o.out_free = !out_valid_q || !out_stall_i;

endmodule
`default_nettype wire

// ===== rtl/pst_ctrl.sv =====
`default_nettype none
module pst_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  input  wire logic          end_of_path_i,
  output logic               in_stall_o,
  input  wire pst_pkg::sts_t sts_i,
  output pst_pkg::cmd_t      cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE, S_DIFF, S_SQX, S_SQY, S_LEN, S_UINIT, S_USTEP, S_USTORE,
    S_OFF, S_EMIT, S_FINISH
  } state_e;

  state_e state_q;
  logic [1:0] pts_q;
  logic end_q, seg_q, seg1_q, nsel_q, comp_q;
  logic [3:0] step_q;
  logic do0, do1;

  assign do0 = (pts_q >= 2'd2);
  assign do1 = end_of_path_i && (pts_q >= 2'd1);
  assign in_stall_o = (state_q != S_IDLE);

  // command decode
  always_comb begin
    cmd_o.seg  = seg_q;
    cmd_o.nsel = nsel_q;
    cmd_o.comp = comp_q;
    cmd_o.idx  = step_q;
    cmd_o.k    = pts_q;
    cmd_o.last = (step_q == 4'd9) && (seg_q || !seg1_q);
    case (state_q)
      S_IDLE:   cmd_o.op = in_valid_i ? pst_pkg::OP_LOAD : pst_pkg::OP_NOP;
      S_DIFF:   cmd_o.op = pst_pkg::OP_DIFF;
      S_SQX:    cmd_o.op = pst_pkg::OP_SQX;
      S_SQY:    cmd_o.op = pst_pkg::OP_SQY;
      S_LEN:    cmd_o.op = pst_pkg::OP_LEN;
      S_UINIT:  cmd_o.op = pst_pkg::OP_UINIT;
      S_USTEP:  cmd_o.op = pst_pkg::OP_USTEP;
      S_USTORE: cmd_o.op = pst_pkg::OP_USTORE;
      S_OFF:    cmd_o.op = pst_pkg::OP_OFF;
      S_EMIT:   cmd_o.op = sts_i.out_free ? pst_pkg::OP_VTX : pst_pkg::OP_NOP;
      S_FINISH: cmd_o.op = pst_pkg::OP_SHIFT;
      default:  cmd_o.op = pst_pkg::OP_NOP;
    endcase
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      pts_q <= '0; end_q <= 1'b0; seg_q <= 1'b0; seg1_q <= 1'b0;
      nsel_q <= 1'b0; comp_q <= 1'b0; step_q <= '0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            end_q  <= end_of_path_i;
            seg_q  <= !do0;
            seg1_q <= do1;
            nsel_q <= 1'b0;
            comp_q <= 1'b0;
            step_q <= '0;
            state_q <= (do0 || do1) ? S_DIFF : S_FINISH;
          end
        end
        S_DIFF:  state_q <= S_SQX;
        S_SQX:   state_q <= S_SQY;
        S_SQY:   state_q <= S_LEN;
        S_LEN:   state_q <= S_UINIT;
        S_UINIT: begin
          step_q  <= '0;
          state_q <= S_USTEP;
        end
        S_USTEP: begin
          step_q <= step_q + 4'd1;
          if (step_q == 4'd15) state_q <= S_USTORE;
        end
        S_USTORE: begin
          step_q <= '0;
          if (!comp_q) begin
            comp_q  <= 1'b1;
            state_q <= S_UINIT;
          end else begin
            comp_q <= 1'b0;
            if (!nsel_q) begin
              nsel_q  <= 1'b1;
              state_q <= S_DIFF;
            end else begin
              state_q <= S_OFF;
            end
          end
        end
        S_OFF: begin
          if (step_q == 4'd7) begin
            step_q  <= '0;
            state_q <= S_EMIT;
          end else begin
            step_q <= step_q + 4'd1;
          end
        end
        S_EMIT: begin
          if (sts_i.out_free) begin
            if (step_q == 4'd9) begin
              step_q <= '0;
              if (!seg_q && seg1_q) begin
                seg_q   <= 1'b1;
                nsel_q  <= 1'b0;
                state_q <= S_DIFF;
              end else begin
                state_q <= S_FINISH;
              end
            end else begin
              step_q <= step_q + 4'd1;
            end
          end
        end
        S_FINISH: begin
          pts_q   <= end_q ? 2'd0 : ((pts_q == 2'd3) ? 2'd3 : pts_q + 2'd1);
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // an accepted point always starts work
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (state_q != S_IDLE))
    else $error("point accepted but controller stayed idle");

  // vertices only go out when the output register can take them
  a_vtx_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.op == pst_pkg::OP_VTX) |-> sts_i.out_free)
    else $error("vertex issued into a full output register");

  // strip index stays within one segment
  a_emit_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EMIT) |-> (step_q <= 4'd9))
    else $error("strip index out of range");

endmodule
`default_nettype wire

// ===== rtl/polyline_stroke_tessellator_top.sv =====
// a point holds in_stall_o high until all of its segments are done, so points are not overlapped
// each segment computes two normals (two 16-step root searches each), then 8 offsets,
// then 10 vertex beats; a stalled output holds the vertex beats back
// reset: asynchronous active low, clears the path history and restores default config
`default_nettype none
module polyline_stroke_tessellator_top (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic signed [15:0] point_x_i,
  input  wire logic signed [15:0] point_y_i,
  input  wire logic               end_of_path_i,
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [1:0]         cfg_index_i,
  input  wire logic [31:0]        cfg_data_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic signed [24:0]      vertex_x_o,
  output logic signed [24:0]      vertex_y_o,
  output logic [7:0]              red_o,
  output logic [7:0]              green_o,
  output logic [7:0]              blue_o,
  output logic [7:0]              alpha_o,
  output logic [3:0]              vertex_index_o,
  output logic                    last_of_item_o
);

  pst_pkg::cmd_t cmd;
  pst_pkg::sts_t sts;

  assign cfg_ready_o = 1'b1;

  // sequencer
  pst_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .end_of_path_i (end_of_path_i),
    .in_stall_o    (in_stall_o),
    .sts_i         (sts),
    .cmd_o         (cmd)
  );

  // geometry datapath
  pst_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .point_x_i      (point_x_i),
    .point_y_i      (point_y_i),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .vertex_x_o     (vertex_x_o),
    .vertex_y_o     (vertex_y_o),
    .red_o          (red_o),
    .green_o        (green_o),
    .blue_o         (blue_o),
    .alpha_o        (alpha_o),
    .vertex_index_o (vertex_index_o),
    .last_of_item_o (last_of_item_o)
  );

endmodule
`default_nettype wire

// ===== tb/tb_polyline_stroke_tessellator_top.sv =====
`default_nettype none
module tb_polyline_stroke_tessellator_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned DRAIN_CYCLES = 250;
  localparam longint VERTEX_SAT = 8389120;

  typedef struct {
    logic signed [24:0] vx;
    logic signed [24:0] vy;
    logic [7:0]         red;
    logic [7:0]         green;
    logic [7:0]         blue;
    logic [7:0]         alpha;
    logic [3:0]         idx;
    logic               last;
  } vertex_t;

  // expected strip vertices for every accepted point
  class stroke_scoreboard;
    logic [31:0] color;
    logic [11:0] inner;
    logic [11:0] feather;
    logic signed [15:0] prev_x, prev_y, older_x, older_y, oldest_x, oldest_y;
    logic [1:0] seen;
    vertex_t vert_q[$];
    int errors;

    function new();
      color = 32'hff000000;
      inner = 12'd230;
      feather = 12'd256;
      {prev_x, prev_y, older_x, older_y, oldest_x, oldest_y} = '0;
      seen = '0;
      errors = 0;
    endfunction

    function void set_reg(logic [1:0] index, logic [31:0] data);
      case (index)
        pst_pkg::CFG_COLOR:   color = data;
        pst_pkg::CFG_INNER:   inner = data[11:0];
        pst_pkg::CFG_FEATHER: feather = data[11:0];
        default: ;
      endcase
    endfunction

    // q1.14 component of d/|d| by exact search, halves away from zero
    function int unit_q14(longint d, longint unsigned len2);
      longint unsigned mag, rhs, t;
      int unsigned lo, hi, mid;
      if (len2 == 0) return 0;
      mag = (d < 0) ? -d : d;
      rhs = (mag * mag) << 30;
      lo = 0;
      hi = 16384;
      while (lo < hi) begin
        mid = (lo + hi + 1) / 2;
        t = 2 * longint'(mid) - 1;
        if (t * t * len2 <= rhs) lo = mid;
        else hi = mid - 1;
      end
      return (d < 0) ? -int'(lo) : int'(lo);
    endfunction

    function longint offset_of(int n, int unsigned w);
      longint unsigned p;
      longint q;
      p = longint'((n < 0) ? -n : n) * w;
      q = longint'((p + 8192) >> 14);
      return (n < 0) ? -q : q;
    endfunction

    function logic signed [24:0] sat_vertex(longint v);
      if (v > VERTEX_SAT) v = VERTEX_SAT;
      if (v < -VERTEX_SAT) v = -VERTEX_SAT;
      return v[24:0];
    endfunction

    // ten strip vertices of segment a->b with neighbors aa and bb
    function void add_segment(longint aax, longint aay, longint ax, longint ay,
                              longint bx, longint by, longint bbx, longint bby);
      longint dx, dy, px, py, ox, oy;
      int nax, nay, nbx, nby, nx, ny;
      int unsigned w;
      bit at_b, neg, outer;
      vertex_t v;
      dx = bx - aax;
      dy = by - aay;
      nax = -unit_q14(dy, dx * dx + dy * dy);
      nay = unit_q14(dx, dx * dx + dy * dy);
      dx = bbx - ax;
      dy = bby - ay;
      nbx = -unit_q14(dy, dx * dx + dy * dy);
      nby = unit_q14(dx, dx * dx + dy * dy);
      for (int j = 0; j < 10; j++) begin
        at_b = (j == 2) || (j == 4) || (j == 6) || (j >= 8);
        neg = (j >= 5);
        outer = (j <= 2) || (j >= 7);
        w = outer ? int'(inner) + int'(feather) : int'(inner);
        nx = at_b ? nbx : nax;
        ny = at_b ? nby : nay;
        px = at_b ? bx : ax;
        py = at_b ? by : ay;
        ox = offset_of(nx, w);
        oy = offset_of(ny, w);
        if (neg) begin
          ox = -ox;
          oy = -oy;
        end
        v.vx = sat_vertex(px * 256 + ox);
        v.vy = sat_vertex(py * 256 + oy);
        v.red = color[23:16];
        v.green = color[15:8];
        v.blue = color[7:0];
        v.alpha = outer ? 8'd0 : color[31:24];
        v.idx = j[3:0];
        v.last = 1'b0;
        vert_q.push_back(v);
      end
    endfunction

    function void note_point(logic signed [15:0] x, logic signed [15:0] y, logic eop);
      int n0;
      n0 = vert_q.size();
      if (seen >= 2)
        add_segment((seen == 3) ? oldest_x : older_x, (seen == 3) ? oldest_y : older_y,
                    older_x, older_y, prev_x, prev_y, x, y);
      if (eop && seen >= 1)
        add_segment((seen >= 2) ? older_x : prev_x, (seen >= 2) ? older_y : prev_y,
                    prev_x, prev_y, x, y, x, y);
      if (vert_q.size() > n0) vert_q[vert_q.size() - 1].last = 1'b1;
      oldest_x = older_x;
      oldest_y = older_y;
      older_x = prev_x;
      older_y = prev_y;
      prev_x = x;
      prev_y = y;
      seen = eop ? 2'd0 : ((seen == 3) ? 2'd3 : seen + 2'd1);
    endfunction

    function void check_field(string name, longint want, longint got);
      if (want != got) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_vertex(vertex_t got);
      vertex_t want;
      if (vert_q.size() == 0) begin
        $error("vertex beat with no vertex expected");
        errors++;
        return;
      end
      want = vert_q.pop_front();
      check_field("vertex_x", want.vx, got.vx);
      check_field("vertex_y", want.vy, got.vy);
      check_field("red", want.red, got.red);
      check_field("green", want.green, got.green);
      check_field("blue", want.blue, got.blue);
      check_field("alpha", want.alpha, got.alpha);
      check_field("vertex_index", want.idx, got.idx);
      check_field("last_of_item", want.last, got.last);
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic signed [15:0] point_x_i = '0;
  logic signed [15:0] point_y_i = '0;
  logic end_of_path_i = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic [1:0] cfg_index_i = '0;
  logic [31:0] cfg_data_i = '0;
  logic out_stall_i = 1'b0;
  logic in_stall_o, cfg_ready_o, out_valid_o, last_of_item_o;
  logic signed [24:0] vertex_x_o, vertex_y_o;
  logic [7:0] red_o, green_o, blue_o, alpha_o;
  logic [3:0] vertex_index_o;

  stroke_scoreboard sb = new();
  int unsigned cycles = 0;
  int points_sent = 0;
  bit no_gaps = 1'b0;

  polyline_stroke_tessellator_top uut (.*);

  always #1 clk_i = ~clk_i;

  // timeout
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_polyline_stroke_tessellator_top: FAIL");
      $finish;
    end
  end

  // check each accepted vertex beat
  always @(posedge clk_i) begin
    vertex_t got;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got.vx = vertex_x_o;
      got.vy = vertex_y_o;
      got.red = red_o;
      got.green = green_o;
      got.blue = blue_o;
      got.alpha = alpha_o;
      got.idx = vertex_index_o;
      got.last = last_of_item_o;
      sb.check_vertex(got);
    end
  end

  // output backpressure: quiet runs, choppy runs, rare long stalls
  initial begin
    int mode;
    forever begin
      mode = $urandom_range(0, 9);
      if (mode < 3) begin
        out_stall_i <= 1'b0;
        repeat ($urandom_range(20, 200)) @(posedge clk_i);
      end else if (mode == 9) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(20, 60)) @(posedge clk_i);
      end else begin
        repeat ($urandom_range(10, 60)) begin
          out_stall_i <= ($urandom_range(0, 99) < 35);
          @(posedge clk_i);
        end
      end
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  // one point beat, followed by a random gap
  task automatic send_point(logic signed [15:0] x, logic signed [15:0] y, logic eop);
    int gap;
    in_valid_i <= 1'b1;
    point_x_i <= x;
    point_y_i <= y;
    end_of_path_i <= eop;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_point(x, y, eop);
    points_sent++;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // hold off until every expected vertex has come and the block settled
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.vert_q.size() != 0) @(posedge clk_i);
    repeat (150) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] index, logic [31:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= index;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.set_reg(index, data);
  endtask

  task automatic write_config(logic [31:0] color, logic [31:0] inner, logic [31:0] feather);
    write_reg(pst_pkg::CFG_COLOR, color);
    write_reg(pst_pkg::CFG_INNER, inner);
    write_reg(pst_pkg::CFG_FEATHER, feather);
    write_reg(pst_pkg::CFG_UNUSED, $urandom());
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic signed [15:0] rand_coord();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 16'($signed($urandom_range(0, 100)) - 50);
    if (r < 80) return 16'($signed($urandom_range(0, 4000)) - 2000);
    if (r < 90) return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
    return 16'($urandom());
  endfunction

  // well-formed paths with random content, some left open or noisy
  task automatic random_paths(int target);
    int len;
    logic signed [15:0] x, y;
    while (points_sent < target) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 14) : $urandom_range(1, 5);
      no_gaps = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < len; i++) begin
        if (i == 0 || $urandom_range(0, 9) != 0) begin
          x = rand_coord();
          y = rand_coord();
        end
        send_point(x, y, (i == len - 1) && ($urandom_range(0, 7) != 0));
      end
      if ($urandom_range(0, 29) == 0) wait_idle();
    end
    no_gaps = 1'b0;
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: single point, short path, zero direction, extremes, long path
    send_point(16'sh7fff, 16'sh8000, 1'b1);
    send_point(16'sd0, 16'sd0, 1'b0);
    send_point(16'sd10, 16'sd0, 1'b1);
    send_point(16'sd5, 16'sd5, 1'b0);
    send_point(16'sd5, 16'sd5, 1'b0);
    send_point(16'sd5, 16'sd5, 1'b1);
    send_point(16'sh8000, 16'sh8000, 1'b0);
    send_point(16'sh7fff, 16'sh7fff, 1'b0);
    send_point(16'sh8000, 16'sh7fff, 1'b0);
    send_point(16'sh7fff, 16'sh8000, 1'b1);
    for (int i = 0; i < 7; i++)
      send_point(16'(i * 3), 16'(i * i - 7), i == 6);
    wait_idle();

    random_paths(110);
    wait_idle();
    write_config(32'hffffffff, 32'hffffffff, 32'hffffffff);
    random_paths(210);
    wait_idle();
    write_config(32'h0, 32'h0, 32'h0);
    random_paths(310);
    wait_idle();
    write_config($urandom(), $urandom(), $urandom());
    random_paths(410);

    // drain
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.vert_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.errors == 0 && sb.vert_q.size() == 0)
      $display("tb_polyline_stroke_tessellator_top: PASS");
    else
      $display("tb_polyline_stroke_tessellator_top: FAIL");
    $finish;
  end

endmodule
`default_nettype wire

// ===== sim.f =====
rtl/pst_pkg.sv
rtl/pst_dp.sv
rtl/pst_ctrl.sv
rtl/polyline_stroke_tessellator_top.sv
tb/tb_polyline_stroke_tessellator_top.sv
